FILE: rtl/rgb_led_effect_generator_unit_defines.svh
// Assertion macros for the checker file of the LED effect generator.
`ifndef RGB_LED_EFFECT_GENERATOR_UNIT_DEFINES_SVH
`define RGB_LED_EFFECT_GENERATOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RLEG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RLEG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rleg_pkg.sv
// Shared constants and types of the LED effect generator.
`default_nettype none

package rleg_pkg;

   // Shared serial divider geometry.
   localparam int DIV_W = 32;
   localparam int DVS_W = 24;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Quotient bits produced for each division of a tick.
   localparam int ITERS_MOD   = 32;
   localparam int ITERS_FRAC  = 32;
   localparam int ITERS_LVL   = 17;
   localparam int ITERS_FADE  = 32;
   localparam int ITERS_SCALE = 15;
   localparam int ITERS_COLOR = 16;

   // Left alignment of a short dividend so that its top bit enters first.
   localparam int SH_LVL   = DIV_W - ITERS_LVL;
   localparam int SH_SCALE = DIV_W - ITERS_SCALE;
   localparam int SH_COLOR = DIV_W - ITERS_COLOR;

   localparam logic [9:0]  FRAC_ONE   = 10'd1000;
   localparam logic [6:0]  PCT_MAX    = 7'd100;
   localparam logic [7:0]  FULL_SCALE = 8'd255;
   localparam logic [21:0] MIN_PERIOD = 22'd200;

   // Operation codes of a request.
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_OFF    = 3'd1;
   localparam logic [2:0] OP_SOLID  = 3'd2;
   localparam logic [2:0] OP_BREATH = 3'd3;
   localparam logic [2:0] OP_FADE   = 3'd4;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_SOLID  = 2'd1,
      MODE_BREATH = 2'd2,
      MODE_FADE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] iters;
   } div_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/rleg_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rleg_serial_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rleg_pkg::div_ctl_type       div_ctl,
   input  wire logic [rleg_pkg::DIV_W-1:0]  dividend,
   input  wire logic [rleg_pkg::DVS_W-1:0]  divisor,
   output logic                             done,
   output logic [rleg_pkg::DIV_W-1:0]       quotient,
   output logic [rleg_pkg::DVS_W-1:0]       remainder
);

   logic [rleg_pkg::DIV_W-1:0] quo_ff;
   logic [rleg_pkg::DVS_W-1:0] rem_ff;
   logic [rleg_pkg::DVS_W-1:0] dvs_ff;
   logic [rleg_pkg::CNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [rleg_pkg::DVS_W:0]   partial;
   logic [rleg_pkg::DVS_W+1:0] diff;

   // The dividend arrives left aligned, so its top bit feeds the remainder first.
   assign partial = {rem_ff, quo_ff[rleg_pkg::DIV_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_ctl.start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= div_ctl.iters;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (diff[rleg_pkg::DVS_W+1]) begin
               rem_ff <= partial[rleg_pkg::DVS_W-1:0];
               quo_ff <= {quo_ff[rleg_pkg::DIV_W-2:0], 1'b0};
            end else begin
               rem_ff <= diff[rleg_pkg::DVS_W-1:0];
               quo_ff <= {quo_ff[rleg_pkg::DIV_W-2:0], 1'b1};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == rleg_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/rgb_led_effect_generator_unit.sv
// LED effect generator: this file holds the top level with the effect sequencer.
// Commands (off, solid, breath, fade) take effect in the cycle they are
// accepted and give no result. A tick that needs no refresh only advances
// the tick count. A tick that refreshes runs a sequence of divisions through
// one shared bit-serial divider that yields one quotient bit per cycle. Off
// and solid ticks run the fewest divisions, fade ticks no fewer and breath
// ticks the most; the block then hands the color to the output register. A
// finished color waits in that register while the next request is taken;
// a later tick stalls at its end until it is free. The brightness cap
// register is written through the csr port while the block is idle; any
// write forces a refresh on the next tick.
`default_nettype none

module rgb_led_effect_generator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_level_pct,
   input  wire logic [7:0]  req_low_pct,
   input  wire logic [7:0]  req_high_pct,
   input  wire logic [21:0] req_period_ms,
   input  wire logic [23:0] req_duration_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_brightness_cap_pct
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FADE_EL,
      ST_FADE_CMP,
      ST_FADE_DIV,
      ST_BR_POS,
      ST_BR_FRAC,
      ST_BR_LVL,
      ST_SCALE1,
      ST_SCALE2,
      ST_RED,
      ST_GREEN,
      ST_BLUE,
      ST_OUT
   } state_type;

   state_type             state_ff;
   rleg_pkg::mode_type    mode_ff;
   logic [6:0]            cap_ff;
   logic [7:0]            color_red_ff;
   logic [7:0]            color_green_ff;
   logic [7:0]            color_blue_ff;
   logic [6:0]            current_level_ff;
   logic [6:0]            fade_from_ff;
   logic [23:0]           fade_length_ff;
   logic [31:0]           fade_start_ff;
   logic [21:0]           breath_period_ff;
   logic [6:0]            breath_low_ff;
   logic [6:0]            breath_high_ff;
   logic [31:0]           tick_count_ff;
   logic                  refresh_ff;
   logic [31:0]           elapsed_ff;
   logic                  lower_half_ff;
   logic [7:0]            applied_ff;
   logic [7:0]            res_red_ff;
   logic [7:0]            res_green_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_red_ff;
   logic [7:0]            rsp_green_ff;
   logic [7:0]            rsp_blue_ff;

   rleg_pkg::div_ctl_type      div_ctl_ff;
   logic [rleg_pkg::DIV_W-1:0] dividend_ff;
   logic [rleg_pkg::DVS_W-1:0] divisor_ff;
   logic                       div_done;
   logic [rleg_pkg::DIV_W-1:0] div_quo;
   logic [rleg_pkg::DVS_W-1:0] div_rem;

   logic                       req_xfer;
   logic                       csr_xfer;
   logic                       animating;
   logic [31:0]                tick_x10;
   logic [6:0]                 span_top;
   logic [6:0]                 span_base;
   logic                       span_neg;
   logic [6:0]                 span_mag;
   logic [6:0]                 interp_pct;
   logic [20:0]                half;
   logic [21:0]                pos;
   logic                       pos_lower;
   logic [21:0]                num;
   logic [9:0]                 frac;
   logic                       fade_done;
   logic [6:0]                 solid_pct;
   logic [23:0]                mul_a_in;
   logic [9:0]                 mul_b_in;
   logic [33:0]                product;
   logic [rleg_pkg::DIV_W-1:0] dividend_in;
   logic [rleg_pkg::DVS_W-1:0] divisor_in;
   logic [rleg_pkg::CNT_W-1:0] iters_in;

   function automatic logic [31:0] times_ten(input logic [31:0] v);
      return (v << 3) + (v << 1);
   endfunction

   function automatic logic [6:0] sat_pct(input logic [7:0] v);
      return (v > {1'b0, rleg_pkg::PCT_MAX}) ? rleg_pkg::PCT_MAX : v[6:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;
   assign animating = (mode_ff == rleg_pkg::MODE_BREATH) || (mode_ff == rleg_pkg::MODE_FADE);
   assign tick_x10  = times_ten(tick_count_ff);

   // Interpolation between two levels, shared by breath and fade.
   assign span_top   = (mode_ff == rleg_pkg::MODE_BREATH) ? breath_high_ff : current_level_ff;
   assign span_base  = (mode_ff == rleg_pkg::MODE_BREATH) ? breath_low_ff : fade_from_ff;
   assign span_neg   = span_top < span_base;
   assign span_mag   = span_neg ? (span_base - span_top) : (span_top - span_base);
   assign interp_pct = span_neg ? (span_base - div_quo[6:0]) : (span_base + div_quo[6:0]);

   // Breath phase: position in the period and its distance into the current half.
   assign half      = breath_period_ff[21:1];
   assign pos       = div_rem[21:0];
   assign pos_lower = pos < {1'b0, half};
   assign num       = pos_lower ? pos : (pos - {1'b0, half});
   assign frac      = lower_half_ff ? div_quo[9:0] : (rleg_pkg::FRAC_ONE - div_quo[9:0]);

   assign fade_done = elapsed_ff >= {8'd0, fade_length_ff};
   assign solid_pct = (mode_ff == rleg_pkg::MODE_SOLID) ? current_level_ff : 7'd0;

   // One multiplier feeds the dividend register of the next division.
   always_comb begin
      mul_a_in = '0;
      mul_b_in = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a_in = {17'd0, solid_pct};
            mul_b_in = {2'd0, rleg_pkg::FULL_SCALE};
         end
         ST_FADE_CMP: begin
            if (fade_done) begin
               mul_a_in = {17'd0, current_level_ff};
               mul_b_in = {2'd0, rleg_pkg::FULL_SCALE};
            end else begin
               mul_a_in = elapsed_ff[23:0];
               mul_b_in = {3'd0, span_mag};
            end
         end
         ST_FADE_DIV, ST_BR_LVL: begin
            mul_a_in = {17'd0, interp_pct};
            mul_b_in = {2'd0, rleg_pkg::FULL_SCALE};
         end
         ST_BR_POS: begin
            mul_a_in = {2'd0, num};
            mul_b_in = rleg_pkg::FRAC_ONE;
         end
         ST_BR_FRAC: begin
            mul_a_in = {14'd0, frac};
            mul_b_in = {3'd0, span_mag};
         end
         ST_SCALE1: begin
            mul_a_in = {16'd0, div_quo[7:0]};
            mul_b_in = {3'd0, cap_ff};
         end
         ST_SCALE2: begin
            mul_a_in = {16'd0, color_red_ff};
            mul_b_in = {2'd0, div_quo[7:0]};
         end
         ST_RED: begin
            mul_a_in = {16'd0, color_green_ff};
            mul_b_in = {2'd0, applied_ff};
         end
         ST_GREEN: begin
            mul_a_in = {16'd0, color_blue_ff};
            mul_b_in = {2'd0, applied_ff};
         end
         default: begin
            mul_a_in = '0;
            mul_b_in = '0;
         end
      endcase
   end

   assign product = 34'(mul_a_in) * 34'(mul_b_in);

   // Operands of the division that the current state launches.
   always_comb begin
      dividend_in = product[31:0] << rleg_pkg::SH_SCALE;
      divisor_in  = {17'd0, rleg_pkg::PCT_MAX};
      iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_SCALE);
      case (state_ff)
         ST_IDLE: begin
            if (mode_ff == rleg_pkg::MODE_BREATH) begin
               dividend_in = tick_x10;
               divisor_in  = {2'd0, breath_period_ff};
               iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_MOD);
            end
         end
         ST_FADE_CMP: begin
            if (!fade_done) begin
               dividend_in = product[31:0];
               divisor_in  = fade_length_ff;
               iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_FADE);
            end
         end
         ST_BR_POS: begin
            dividend_in = product[31:0];
            divisor_in  = {3'd0, half};
            iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_FRAC);
         end
         ST_BR_FRAC: begin
            dividend_in = product[31:0] << rleg_pkg::SH_LVL;
            divisor_in  = {14'd0, rleg_pkg::FRAC_ONE};
            iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_LVL);
         end
         ST_SCALE2, ST_RED, ST_GREEN: begin
            dividend_in = product[31:0] << rleg_pkg::SH_COLOR;
            divisor_in  = {16'd0, rleg_pkg::FULL_SCALE};
            iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_COLOR);
         end
         default: begin
            dividend_in = product[31:0] << rleg_pkg::SH_SCALE;
            divisor_in  = {17'd0, rleg_pkg::PCT_MAX};
            iters_in    = rleg_pkg::CNT_W'(rleg_pkg::ITERS_SCALE);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         mode_ff           <= rleg_pkg::MODE_OFF;
         cap_ff            <= rleg_pkg::PCT_MAX;
         color_red_ff      <= '0;
         color_green_ff    <= '0;
         color_blue_ff     <= '0;
         current_level_ff  <= '0;
         fade_from_ff      <= '0;
         fade_length_ff    <= '0;
         fade_start_ff     <= '0;
         breath_period_ff  <= rleg_pkg::MIN_PERIOD;
         breath_low_ff     <= '0;
         breath_high_ff    <= '0;
         tick_count_ff     <= '0;
         refresh_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         div_ctl_ff        <= '0;
      end else begin
         div_ctl_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (csr_xfer) begin
                  cap_ff     <= sat_pct({1'b0, csr_brightness_cap_pct});
                  refresh_ff <= 1'b1;
               end
               if (req_xfer) begin
                  unique case (req_operation)
                     rleg_pkg::OP_TICK: begin
                        refresh_ff <= animating;
                        if (animating || refresh_ff) begin
                           if (mode_ff == rleg_pkg::MODE_FADE) begin
                              elapsed_ff <= tick_count_ff - fade_start_ff;
                              state_ff   <= ST_FADE_EL;
                           end else begin
                              div_ctl_ff  <= '{start: 1'b1, iters: iters_in};
                              dividend_ff <= dividend_in;
                              divisor_ff  <= divisor_in;
                              state_ff    <= (mode_ff == rleg_pkg::MODE_BREATH) ?
                                             ST_BR_POS : ST_SCALE1;
                           end
                        end else begin
                           tick_count_ff <= tick_count_ff + 32'd1;
                        end
                     end
                     rleg_pkg::OP_OFF: begin
                        mode_ff    <= rleg_pkg::MODE_OFF;
                        refresh_ff <= 1'b1;
                     end
                     rleg_pkg::OP_SOLID: begin
                        color_red_ff     <= req_red_in;
                        color_green_ff   <= req_green_in;
                        color_blue_ff    <= req_blue_in;
                        current_level_ff <= sat_pct(req_level_pct);
                        mode_ff          <= rleg_pkg::MODE_SOLID;
                        refresh_ff       <= 1'b1;
                     end
                     rleg_pkg::OP_BREATH: begin
                        color_red_ff     <= req_red_in;
                        color_green_ff   <= req_green_in;
                        color_blue_ff    <= req_blue_in;
                        breath_period_ff <= (req_period_ms < rleg_pkg::MIN_PERIOD) ?
                                            rleg_pkg::MIN_PERIOD : req_period_ms;
                        breath_low_ff    <= sat_pct(req_low_pct);
                        breath_high_ff   <= sat_pct(req_high_pct);
                        mode_ff          <= rleg_pkg::MODE_BREATH;
                        refresh_ff       <= 1'b1;
                     end
                     rleg_pkg::OP_FADE: begin
                        color_red_ff     <= req_red_in;
                        color_green_ff   <= req_green_in;
                        color_blue_ff    <= req_blue_in;
                        fade_from_ff     <= current_level_ff;
                        current_level_ff <= sat_pct(req_level_pct);
                        fade_length_ff   <= req_duration_ms;
                        fade_start_ff    <= tick_count_ff;
                        mode_ff          <= rleg_pkg::MODE_FADE;
                        refresh_ff       <= 1'b1;
                     end
                     default: begin
                        // Unused operation codes leave the state alone.
                        refresh_ff <= refresh_ff;
                     end
                  endcase
               end
            end
            ST_FADE_EL: begin
               elapsed_ff <= times_ten(elapsed_ff);
               state_ff   <= ST_FADE_CMP;
            end
            ST_FADE_CMP: begin
               // A fade whose time has run out settles on its target level.
               if (fade_done) begin
                  mode_ff  <= rleg_pkg::MODE_SOLID;
                  state_ff <= ST_SCALE1;
               end else begin
                  state_ff <= ST_FADE_DIV;
               end
               div_ctl_ff  <= '{start: 1'b1, iters: iters_in};
               dividend_ff <= dividend_in;
               divisor_ff  <= divisor_in;
            end
            ST_FADE_DIV, ST_BR_LVL, ST_SCALE1, ST_RED, ST_GREEN: begin
               if (div_done) begin
                  div_ctl_ff  <= '{start: 1'b1, iters: iters_in};
                  dividend_ff <= dividend_in;
                  divisor_ff  <= divisor_in;
                  if (state_ff == ST_RED) begin
                     res_red_ff <= div_quo[7:0];
                     state_ff   <= ST_GREEN;
                  end else if (state_ff == ST_GREEN) begin
                     res_green_ff <= div_quo[7:0];
                     state_ff     <= ST_BLUE;
                  end else if (state_ff == ST_SCALE1) begin
                     state_ff <= ST_SCALE2;
                  end else begin
                     state_ff <= ST_SCALE1;
                  end
               end
            end
            ST_BR_POS: begin
               if (div_done) begin
                  lower_half_ff <= pos_lower;
                  div_ctl_ff    <= '{start: 1'b1, iters: iters_in};
                  dividend_ff   <= dividend_in;
                  divisor_ff    <= divisor_in;
                  state_ff      <= ST_BR_FRAC;
               end
            end
            ST_BR_FRAC: begin
               if (div_done) begin
                  div_ctl_ff  <= '{start: 1'b1, iters: iters_in};
                  dividend_ff <= dividend_in;
                  divisor_ff  <= divisor_in;
                  state_ff    <= ST_BR_LVL;
               end
            end
            ST_SCALE2: begin
               if (div_done) begin
                  applied_ff  <= div_quo[7:0];
                  div_ctl_ff  <= '{start: 1'b1, iters: iters_in};
                  dividend_ff <= dividend_in;
                  divisor_ff  <= divisor_in;
                  state_ff    <= ST_RED;
               end
            end
            ST_BLUE: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // The blue quotient stays in the divider until the next launch.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_red_ff    <= res_red_ff;
                  rsp_green_ff  <= res_green_ff;
                  rsp_blue_ff   <= div_quo[7:0];
                  tick_count_ff <= tick_count_ff + 32'd1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   rleg_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_ctl   (div_ctl_ff),
      .dividend  (dividend_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;

endmodule

`default_nettype wire

FILE: rtl/rleg_assert.sv
// Port-level assertions for the LED effect generator and their bind.
`default_nettype none

`include "rgb_led_effect_generator_unit_defines.svh"

module rleg_assert (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [2:0]  req_operation,
   input wire logic [7:0]  req_red_in,
   input wire logic [7:0]  req_green_in,
   input wire logic [7:0]  req_blue_in,
   input wire logic [7:0]  req_level_pct,
   input wire logic [7:0]  req_low_pct,
   input wire logic [7:0]  req_high_pct,
   input wire logic [21:0] req_period_ms,
   input wire logic [23:0] req_duration_ms,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_red_out,
   input wire logic [7:0]  rsp_green_out,
   input wire logic [7:0]  rsp_blue_out,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [6:0]  csr_brightness_cap_pct
);

   // A stalled color stays offered unchanged.
   `RLEG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out), "rsp changed while stalled")

   // No request can produce a color in the cycle right after its transfer.
   `RLEG_ASSERT_NEXT(a_no_quick_rsp, req_valid && req_ready, !$rose(rsp_valid), "rsp rose right after a request transfer")

   // Register writes and requests never transfer together.
   `RLEG_ASSERT_NOW(a_one_writer, csr_valid && csr_ready, !(req_valid && req_ready), "csr and req transferred together")

   // While a tick is being worked on, the register port is closed as well.
   `RLEG_ASSERT_NOW(a_busy_blocks_csr, !req_ready, !csr_ready, "csr open while busy")

endmodule

bind rgb_led_effect_generator_unit rleg_assert u_rleg_assert (.*);

`default_nettype wire
